### rtl/kbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbr_pkg
// Shared widths and default settings for the k best ratio selector.
// ----------------------------------------------------------------------------
package kbr_pkg;

	// item field widths
	localparam int VALUE_W  = 20;
	localparam int INDEX_W  = 11;
	localparam int PICK_W   = 7;
	localparam int INT_BITS = 20;

	// upper bound on the number of picks
	localparam int MAX_PICK = 64;

	// default build settings
	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int ITERATIONS_DEF = 56;
	localparam int FRAC_BITS_DEF  = 16;

endpackage
`default_nettype wire

### rtl/kbr_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbr_store
// Value and weight store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kbr_store #(
	parameter int MAX_ITEMS = kbr_pkg::MAX_ITEMS_DEF,
	parameter int AW        = 10
) (
	input  wire                        clk,
	input  wire                        wr_en,
	input  wire [AW-1:0]               wr_addr,
	input  wire [kbr_pkg::VALUE_W-1:0] wr_value,
	input  wire [kbr_pkg::VALUE_W-1:0] wr_weight,
	input  wire [AW-1:0]               rd_addr,
	output logic [kbr_pkg::VALUE_W-1:0] rd_value,
	output logic [kbr_pkg::VALUE_W-1:0] rd_weight
);

	logic [kbr_pkg::VALUE_W-1:0] value_mem [MAX_ITEMS];
	logic [kbr_pkg::VALUE_W-1:0] weight_mem [MAX_ITEMS];

	// write the incoming item
	always_ff @(posedge clk) begin
		if (wr_en) begin
			value_mem[wr_addr]  <= wr_value;
			weight_mem[wr_addr] <= wr_weight;
		end
	end

	// read one entry per cycle
	always_ff @(posedge clk) begin
		rd_value  <= value_mem[rd_addr];
		rd_weight <= weight_mem[rd_addr];
	end

endmodule
`default_nettype wire

### rtl/kbr_key_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kbr_key_unit
// Two-stage key pipeline: key = value * 2^FRAC_BITS - weight * ratio.
// ----------------------------------------------------------------------------
module kbr_key_unit #(
	parameter int FRAC_BITS = kbr_pkg::FRAC_BITS_DEF,
	parameter int AW        = 10,
	parameter int RW        = kbr_pkg::INT_BITS + kbr_pkg::FRAC_BITS_DEF,
	parameter int KW        = kbr_pkg::VALUE_W + RW + 2
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        valid_s1,
	input  wire [AW-1:0]               idx_s1,
	input  wire [kbr_pkg::VALUE_W-1:0] value_s1,
	input  wire [kbr_pkg::VALUE_W-1:0] weight_s1,
	input  wire [RW-1:0]               ratio,
	output logic                       valid_s3,
	output logic [AW-1:0]              idx_s3,
	output logic signed [KW-1:0]       key_s3,
	output logic                       busy
);

	localparam int PW = kbr_pkg::VALUE_W + RW;

	logic          valid_s2;
	logic [AW-1:0] idx_s2;
	logic [PW-1:0] pos_s2;
	logic [PW-1:0] prod_s2;
	logic [PW-1:0] prod_c;

	assign prod_c = PW'(weight_s1) * PW'(ratio);
	assign busy   = valid_s2 | valid_s3;

	// advance the valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// multiply, then subtract
	always_ff @(posedge clk) begin
		idx_s2  <= idx_s1;
		pos_s2  <= PW'(value_s1) << FRAC_BITS;
		prod_s2 <= prod_c;
		idx_s3  <= idx_s2;
		key_s3  <= $signed({2'b00, pos_s2}) - $signed({2'b00, prod_s2});
	end

endmodule
`default_nettype wire

### rtl/k_best_ratio_selector_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_best_ratio_selector_unit
// Loads (value, weight) items, bisects the best average ratio of k items and
// emits the indices of the k best items at the final ratio.
// ----------------------------------------------------------------------------
// Loading: one item per cycle, no result.
// Final item: one scan of the store per pick, in every bisection step and in
// the final pass (single read port and key multiplier), plus a setup state per
// step and an output handshake per index.
// Input is stalled from the final item until the last index is taken.
// Reset clears the item count and low bound, sets the high bound to its top and the pick count to 1.
module k_best_ratio_selector_unit #(
	parameter int MAX_ITEMS  = kbr_pkg::MAX_ITEMS_DEF,
	parameter int ITERATIONS = kbr_pkg::ITERATIONS_DEF,
	parameter int FRAC_BITS  = kbr_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_wr_en,
	input  wire [kbr_pkg::PICK_W-1:0]   cfg_wr_data,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  wire [kbr_pkg::VALUE_W-1:0]  item_value,
	input  wire [kbr_pkg::VALUE_W-1:0]  item_weight,
	input  wire                         last_item,
	output logic                        out_valid,
	input  wire                         out_stall,
	output logic [kbr_pkg::INDEX_W-1:0] chosen_index,
	output logic                        last_chosen,
	output logic                        too_few_items
);

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int TW = (CW > kbr_pkg::PICK_W) ? CW : kbr_pkg::PICK_W;
	localparam int IW = $clog2(ITERATIONS + 1);
	localparam int RW = kbr_pkg::INT_BITS + FRAC_BITS;
	localparam int KW = kbr_pkg::VALUE_W + RW + 2;
	localparam int SW = KW + 7;
	localparam int PW = kbr_pkg::PICK_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MID,
		ST_SCAN,
		ST_OUT
	} state_t;

	state_t               state_q;
	logic                 emit_q;
	logic [PW-1:0]        pick_q;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        n_q;
	logic [PW-1:0]        take_q;
	logic                 few_q;
	logic [RW-1:0]        low_q;
	logic [RW:0]          high_q;
	logic [RW-1:0]        m_q;
	logic [IW-1:0]        iter_q;
	logic [PW-1:0]        r_q;
	logic                 first_q;
	logic signed [SW-1:0] sum_q;
	logic [CW-1:0]        addr_q;
	logic                 rd_v_s1;
	logic [AW-1:0]        rd_idx_s1;
	logic                 found_q;
	logic signed [KW-1:0] best_key_q;
	logic [AW-1:0]        best_idx_q;
	logic signed [KW-1:0] prev_key_q;
	logic [AW-1:0]        prev_idx_q;

	logic                        in_acc;
	logic                        store_ok;
	logic [CW-1:0]               count_nx;
	logic [PW-1:0]               k_c;
	logic [kbr_pkg::VALUE_W-1:0] rd_value;
	logic [kbr_pkg::VALUE_W-1:0] rd_weight;
	logic                        key_v_s3;
	logic [AW-1:0]               key_idx_s3;
	logic signed [KW-1:0]        key_s3;
	logic                        key_busy;
	logic                        issue;
	logic                        pass_done;
	logic                        gt_best;
	logic                        lt_prev;
	logic                        take_cand;
	logic signed [SW-1:0]        sum_nx;
	logic [RW-1:0]               mid_c;

	// input handshake and store fill
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign store_ok = (count_q < CW'(MAX_ITEMS));
	assign count_nx = store_ok ? count_q + CW'(1) : count_q;

	// clamp the pick count into one to MAX_PICK
	always_comb begin
		if (pick_q == '0) begin
			k_c = PW'(1);
		end else if (pick_q > PW'(kbr_pkg::MAX_PICK)) begin
			k_c = PW'(kbr_pkg::MAX_PICK);
		end else begin
			k_c = pick_q;
		end
	end

	kbr_store #(
		.MAX_ITEMS (MAX_ITEMS),
		.AW        (AW)
	) u_store (
		.clk       (clk),
		.wr_en     (in_acc && store_ok),
		.wr_addr   (count_q[AW-1:0]),
		.wr_value  (item_value),
		.wr_weight (item_weight),
		.rd_addr   (addr_q[AW-1:0]),
		.rd_value  (rd_value),
		.rd_weight (rd_weight)
	);

	kbr_key_unit #(
		.FRAC_BITS (FRAC_BITS),
		.AW        (AW),
		.RW        (RW),
		.KW        (KW)
	) u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (rd_v_s1),
		.idx_s1    (rd_idx_s1),
		.value_s1  (rd_value),
		.weight_s1 (rd_weight),
		.ratio     (m_q),
		.valid_s3  (key_v_s3),
		.idx_s3    (key_idx_s3),
		.key_s3    (key_s3),
		.busy      (key_busy)
	);

	// scan control and candidate ordering (larger key, then larger index)
	assign issue     = (state_q == ST_SCAN) && (addr_q != n_q);
	assign pass_done = (state_q == ST_SCAN) && (addr_q == n_q) && !rd_v_s1 && !key_busy;
	assign gt_best   = (key_s3 > best_key_q) ||
	                   ((key_s3 == best_key_q) && (key_idx_s3 > best_idx_q));
	assign lt_prev   = (key_s3 < prev_key_q) ||
	                   ((key_s3 == prev_key_q) && (key_idx_s3 < prev_idx_q));
	assign take_cand = key_v_s3 && (first_q || lt_prev) && (!found_q || gt_best);
	assign sum_nx    = sum_q + SW'(best_key_q);
	assign mid_c     = RW'(({2'b00, low_q} + {1'b0, high_q}) >> 1);

	// read tag stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[AW-1:0];
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			emit_q        <= 1'b0;
			pick_q        <= PW'(1);
			count_q       <= '0;
			n_q           <= '0;
			take_q        <= '0;
			few_q         <= 1'b0;
			low_q         <= '0;
			high_q        <= {1'b1, {RW{1'b0}}};
			m_q           <= '0;
			iter_q        <= '0;
			r_q           <= '0;
			first_q       <= 1'b1;
			sum_q         <= '0;
			addr_q        <= '0;
			found_q       <= 1'b0;
			best_key_q    <= '0;
			best_idx_q    <= '0;
			prev_key_q    <= '0;
			prev_idx_q    <= '0;
			out_valid     <= 1'b0;
			chosen_index  <= '0;
			last_chosen   <= 1'b0;
			too_few_items <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				pick_q <= cfg_wr_data;
			end
			if (issue) begin
				addr_q <= addr_q + CW'(1);
			end
			if (take_cand) begin
				found_q    <= 1'b1;
				best_key_q <= key_s3;
				best_idx_q <= key_idx_s3;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						count_q <= count_nx;
						if (last_item) begin
							n_q     <= count_nx;
							few_q   <= (TW'(count_nx) < TW'(k_c));
							take_q  <= (TW'(count_nx) < TW'(k_c)) ? PW'(count_nx) : k_c;
							low_q   <= '0;
							high_q  <= {1'b1, {RW{1'b0}}};
							iter_q  <= '0;
							emit_q  <= 1'b0;
							state_q <= ST_MID;
						end
					end
				end
				ST_MID: begin
					// set the trial ratio and start the first pass
					if (iter_q == IW'(ITERATIONS)) begin
						m_q    <= low_q;
						emit_q <= 1'b1;
					end else begin
						m_q <= mid_c;
					end
					r_q     <= '0;
					first_q <= 1'b1;
					sum_q   <= '0;
					addr_q  <= '0;
					found_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (pass_done) begin
						prev_key_q <= best_key_q;
						prev_idx_q <= best_idx_q;
						if (emit_q) begin
							out_valid     <= 1'b1;
							chosen_index  <= kbr_pkg::INDEX_W'({1'b0, best_idx_q} + (AW + 1)'(1));
							last_chosen   <= (r_q + PW'(1) == take_q);
							too_few_items <= few_q;
							state_q       <= ST_OUT;
						end else if (r_q + PW'(1) == take_q) begin
							// decide the bisection step
							if (sum_nx > 0) begin
								low_q <= m_q;
							end else begin
								high_q <= {1'b0, m_q};
							end
							iter_q  <= iter_q + IW'(1);
							state_q <= ST_MID;
						end else begin
							sum_q   <= sum_nx;
							r_q     <= r_q + PW'(1);
							first_q <= 1'b0;
							addr_q  <= '0;
							found_q <= 1'b0;
						end
					end
				end
				ST_OUT: begin
					// hold the item until taken
					if (!out_stall) begin
						out_valid <= 1'b0;
						if (last_chosen) begin
							count_q <= '0;
							low_q   <= '0;
							high_q  <= {1'b1, {RW{1'b0}}};
							emit_q  <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							r_q     <= r_q + PW'(1);
							first_q <= 1'b0;
							addr_q  <= '0;
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### dv/k_best_ratio_selector_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// k_best_ratio_selector_unit_tb
// Loads sets of (value, weight) items into the selector and checks every
// chosen index against a fixed point bisection predictor, under several
// sender and receiver idling patterns and one long output hold-off.
// ----------------------------------------------------------------------------
module k_best_ratio_selector_unit_tb;

	localparam int  STORE_DEPTH = kbr_pkg::MAX_ITEMS_DEF;
	localparam int  STEPS       = kbr_pkg::ITERATIONS_DEF;
	localparam int  FRAC        = kbr_pkg::FRAC_BITS_DEF;
	localparam int  SETTLE      = 40;
	localparam longint CYCLE_LIMIT = 5000000;

	typedef struct packed {
		logic [kbr_pkg::INDEX_W-1:0] index;
		logic                        last;
		logic                        few;
	} pick_t;

	// bisection predictor and store of expected picks
	class ratio_scoreboard;
		logic [kbr_pkg::VALUE_W-1:0] values[$];
		logic [kbr_pkg::VALUE_W-1:0] weights[$];
		logic [kbr_pkg::PICK_W-1:0]  pick_reg;
		pick_t                       expected_picks[$];
		int                          ranked[$];
		int                          mismatches;

		function new();
			pick_reg   = 1;
			mismatches = 0;
		endfunction

		function void set_pick(logic [kbr_pkg::PICK_W-1:0] k);
			pick_reg = k;
		endfunction

		// order the first take items by key at ratio m, larger index wins ties
		function longint rank_keys(longint m, int take);
			longint keys[$];
			bit     used[$];
			longint sum;
			int     best;
			keys.delete();
			used.delete();
			ranked.delete();
			sum = 0;
			foreach (values[i]) begin
				keys.push_back((longint'(values[i]) << FRAC) - longint'(weights[i]) * m);
				used.push_back(1'b0);
			end
			for (int r = 0; r < take; r++) begin
				best = -1;
				foreach (keys[i])
					if (!used[i] && (best < 0 || keys[i] >= keys[best]))
						best = i;
				used[best] = 1'b1;
				ranked.push_back(best);
				sum += keys[best];
			end
			return sum;
		endfunction

		function void note_item(logic [kbr_pkg::VALUE_W-1:0] v,
				logic [kbr_pkg::VALUE_W-1:0] w, logic last);
			int     n, k, take;
			bit     few;
			longint lo, hi, m;
			pick_t  p;
			if (values.size() < STORE_DEPTH) begin
				values.push_back(v);
				weights.push_back(w);
			end
			if (!last)
				return;
			n = values.size();
			k = (pick_reg == 0) ? 1 :
				(pick_reg > kbr_pkg::MAX_PICK) ? kbr_pkg::MAX_PICK : pick_reg;
			few  = n < k;
			take = few ? n : k;
			lo = 0;
			hi = longint'(1) << (kbr_pkg::INT_BITS + FRAC);
			for (int s = 0; s < STEPS; s++) begin
				m = (lo + hi) >> 1;
				if (rank_keys(m, take) > 0)
					lo = m;
				else
					hi = m;
			end
			void'(rank_keys(lo, take));
			foreach (ranked[r]) begin
				p.index = kbr_pkg::INDEX_W'(ranked[r] + 1);
				p.last  = (r == take - 1);
				p.few   = few;
				expected_picks.push_back(p);
			end
			values.delete();
			weights.delete();
		endfunction

		function void check_pick(pick_t got);
			pick_t want;
			if (expected_picks.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected pick: index %0d last %0d few %0d",
						got.index, got.last, got.few);
				return;
			end
			want = expected_picks.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("pick mismatch: expected index %0d last %0d few %0d, got %0d %0d %0d",
						want.index, want.last, want.few, got.index, got.last, got.few);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [kbr_pkg::PICK_W-1:0]    cfg_wr_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [kbr_pkg::VALUE_W-1:0]   item_value;
	logic [kbr_pkg::VALUE_W-1:0]   item_weight;
	logic                          last_item;
	logic                          out_valid;
	logic                          out_stall;
	logic [kbr_pkg::INDEX_W-1:0]   chosen_index;
	logic                          last_chosen;
	logic                          too_few_items;

	ratio_scoreboard sb;
	int     send_idle_pct;
	int     recv_stall_pct;
	bit     hold_request;
	int     hold_left;
	longint cycles;

	k_best_ratio_selector_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.item_value   (item_value),
		.item_weight  (item_weight),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.chosen_index (chosen_index),
		.last_chosen  (last_chosen),
		.too_few_items(too_few_items)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// drop out on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall, or a counted long hold-off once a pick is offered
	always @(posedge clk) begin
		if (hold_request && hold_left == 0 && out_valid) begin
			hold_request = 1'b0;
			hold_left    = 800;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// check each accepted pick
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_pick({chosen_index, last_chosen, too_few_items});
	end

	// offer one item, idling first at random, and hold it until taken
	task send_item(input logic [kbr_pkg::VALUE_W-1:0] v,
			input logic [kbr_pkg::VALUE_W-1:0] w, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		item_value  <= v;
		item_weight <= w;
		last_item   <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(v, w, last);
	endtask

	task wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task write_pick(input logic [kbr_pkg::PICK_W-1:0] k);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= k;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_pick(k);
	endtask

	// one set of n items; narrow sets keep values small so ratios stay close
	task send_set(input int n, input bit narrow);
		logic [kbr_pkg::VALUE_W-1:0] v, w;
		for (int i = 0; i < n; i++) begin
			if (narrow) begin
				v = kbr_pkg::VALUE_W'($urandom_range(40));
				w = kbr_pkg::VALUE_W'($urandom_range(40));
			end else begin
				v = kbr_pkg::VALUE_W'($urandom);
				w = kbr_pkg::VALUE_W'($urandom);
			end
			send_item(v, w, i == n - 1);
		end
	endtask

	initial begin
		sb             = new();
		cycles         = 0;
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		in_valid       = 1'b0;
		item_value     = '0;
		item_weight    = '0;
		last_item      = 1'b0;
		out_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		hold_left      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single zero item at reset pick count
		send_item(20'h0, 20'h0, 1'b1);
		// field extremes, zero weights and equal keys
		write_pick(kbr_pkg::PICK_W'(2));
		send_item(20'hFFFFF, 20'hFFFFF, 1'b0);
		send_item(20'hFFFFF, 20'h0, 1'b0);
		send_item(20'h0, 20'hFFFFF, 1'b0);
		send_item(20'h1, 20'h1, 1'b1);
		write_pick(kbr_pkg::PICK_W'(3));
		for (int i = 0; i < 5; i++)
			send_item(20'd7, 20'd3, i == 4);
		// zero pick count acts as one
		write_pick(kbr_pkg::PICK_W'(0));
		send_set(3, 1'b0);
		// oversize pick count clamps to 64, fewer items flagged
		write_pick(7'h7F);
		send_set(3, 1'b1);
		// largest real pick count
		write_pick(kbr_pkg::PICK_W'(64));
		send_set(65, 1'b1);

		// random sets over the idling phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 29) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 29) : 0;
			for (int s = 0; s < 3; s++) begin
				if ($urandom_range(3) == 0)
					write_pick(kbr_pkg::PICK_W'($urandom_range(127)));
				else
					write_pick(kbr_pkg::PICK_W'($urandom_range(1, 8)));
				// hold the picks of one set while the next set is offered
				if (ph == 2 && s == 1) begin
					hold_request = 1'b1;
					send_set($urandom_range(1, 8), $urandom_range(1));
				end
				send_set($urandom_range(1, 8), $urandom_range(1));
			end
		end

		wait_idle();
		if (sb.mismatches == 0 && sb.expected_picks.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

### k_best_ratio_selector_unit.f
rtl/kbr_pkg.sv
rtl/kbr_store.sv
rtl/kbr_key_unit.sv
rtl/k_best_ratio_selector_unit.sv
dv/k_best_ratio_selector_unit_tb.sv
